// ----- rtl/core/dmm_pkg.sv -----
// Package for the dense matrix multiply block: shared widths, command codes,
// register indexes, controller state type and controller/datapath structs.
// No dependencies.
package dmm_pkg;

  localparam int CFG_W  = 7;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 16;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 40;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [1:0] CMD_WRITE_A = 2'd0;
  localparam logic [1:0] CMD_WRITE_B = 2'd1;
  localparam logic [1:0] CMD_REQUEST = 2'd2;

  localparam logic REG_MATRIX_SIZE = 1'b0;
  localparam logic REG_STRIP_ROWS  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_a;
    logic write_b;
    logic start;
    logic issue;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic a_ok;
    logic b_ok;
    logic req_ok;
    logic k_last;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/dense_matrix_multiply.sv -----
// Dense matrix multiply: a strip of rows of A times a square matrix B, with
// signed Q8.8 elements and exact signed Q24.16 product elements.
// Depends on dmm_pkg, dmm_ctrl and dmm_datapath.
//
// Each request on the item channel either writes one element of A or B
// (cmd write A / write B, with row, col and value) or asks for one product
// element (cmd request, with row and col). Writes give no result; a write
// whose row or column lies outside the configured sizes is dropped, as is
// the unused command code. A product request for an in-range (row, col)
// returns the dot product of A row `row` with B column `col` over
// matrix_size terms, clipped to MAX_N; one A and one B element are read per
// cycle from single-ported element memories, and each term passes the read,
// multiply and accumulate registers before the sum is loaded into the
// result register once it is free. An out-of-range request goes straight
// to the finish state and loads error set and product zero into the result
// register once it is free. The item channel
// stalls while a request is in progress; writes keep being accepted while
// a finished result waits in the output register. The element memories are
// not cleared at reset: reading an element before it was written returns
// an unspecified value. Configuration writes (matrix_size, strip_rows) must
// only be made while no request is in progress.
module dense_matrix_multiply #(
  parameter int MAX_N = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [dmm_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        cmd,
  input  logic [dmm_pkg::POS_W-1:0]         row,
  input  logic [dmm_pkg::POS_W-1:0]         col,
  input  logic signed [dmm_pkg::VAL_W-1:0]  value,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [dmm_pkg::PROD_W-1:0] product,
  output logic                              error
);

  // Command and status between the controller and the datapath.
  dmm_pkg::ctrl_cmd_t  ctrl;
  dmm_pkg::dp_status_t status;

  // The controller owns the item handshake and sequences each request.
  dmm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .cmd        (cmd),
    .status     (status),
    .item_stall (item_stall),
    .ctrl       (ctrl)
  );

  // The datapath holds the sizes, the element memories, the multiply-
  // accumulate pipeline and the result register that drives the output.
  dmm_datapath #(
    .MAX_N (MAX_N)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .row          (row),
    .col          (col),
    .value        (value),
    .result_stall (result_stall),
    .ctrl         (ctrl),
    .status       (status),
    .result_valid (result_valid),
    .product      (product),
    .error        (error)
  );

endmodule

// ----- rtl/core/dmm_ctrl.sv -----
// Controller state machine of the dense matrix multiply block.
// Depends on dmm_pkg for the state type, command codes and structs.
module dmm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic [1:0]          cmd,
  input  dmm_pkg::dp_status_t status,
  output logic                item_stall,
  output dmm_pkg::ctrl_cmd_t  ctrl
);

  dmm_pkg::state_t state;
  dmm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    item_stall = 1'b1;
    case (state)
      dmm_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          case (cmd)
            dmm_pkg::CMD_WRITE_A: ctrl.write_a = status.a_ok;
            dmm_pkg::CMD_WRITE_B: ctrl.write_b = status.b_ok;
            dmm_pkg::CMD_REQUEST: begin
              ctrl.start = 1'b1;
              state_next = status.req_ok ? dmm_pkg::ST_RUN : dmm_pkg::ST_FINISH;
            end
            default: ;
          endcase
        end
      end
      dmm_pkg::ST_RUN: begin
        ctrl.issue = 1'b1;
        if (status.k_last) begin
          state_next = dmm_pkg::ST_DRAIN;
        end
      end
      dmm_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = dmm_pkg::ST_FINISH;
        end
      end
      dmm_pkg::ST_FINISH: begin
        if (status.out_free) begin
          ctrl.load_out = 1'b1;
          state_next    = dmm_pkg::ST_IDLE;
        end
      end
      default: state_next = dmm_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/dmm_datapath.sv -----
// Datapath of the dense matrix multiply block: size registers, A and B
// element memories, multiply-accumulate pipeline and result register.
// Depends on dmm_pkg for widths, register indexes and structs.
module dmm_datapath #(
  parameter int MAX_N = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [dmm_pkg::CFG_W-1:0]        cfg_data,
  input  logic [dmm_pkg::POS_W-1:0]        row,
  input  logic [dmm_pkg::POS_W-1:0]        col,
  input  logic signed [dmm_pkg::VAL_W-1:0] value,
  input  logic                             result_stall,
  input  dmm_pkg::ctrl_cmd_t               ctrl,
  output dmm_pkg::dp_status_t              status,
  output logic                             result_valid,
  output logic signed [dmm_pkg::PROD_W-1:0] product,
  output logic                             error
);

  localparam int DEPTH  = MAX_N * MAX_N;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [dmm_pkg::CFG_W-1:0] matrix_size;
  logic [dmm_pkg::CFG_W-1:0] strip_rows;
  logic [dmm_pkg::CFG_W-1:0] n_use;
  logic [dmm_pkg::CFG_W-1:0] rows_use;

  logic signed [dmm_pkg::VAL_W-1:0] a_mem [DEPTH];
  logic signed [dmm_pkg::VAL_W-1:0] b_mem [DEPTH];

  logic [dmm_pkg::POS_W-1:0] row_q;
  logic [dmm_pkg::POS_W-1:0] col_q;
  logic [dmm_pkg::CFG_W-1:0] k;
  logic                      err_q;
  logic [ADDR_W-1:0]         waddr;
  logic [ADDR_W-1:0]         a_raddr;
  logic [ADDR_W-1:0]         b_raddr;

  logic signed [dmm_pkg::VAL_W-1:0]  a_rd;
  logic signed [dmm_pkg::VAL_W-1:0]  b_rd;
  logic signed [dmm_pkg::MUL_W-1:0]  mul;
  logic signed [dmm_pkg::PROD_W-1:0] acc;
  logic                              s1_v;
  logic                              s2_v;
  logic                              taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= dmm_pkg::CFG_RESET;
      strip_rows  <= dmm_pkg::CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dmm_pkg::REG_MATRIX_SIZE: matrix_size <= cfg_data;
        dmm_pkg::REG_STRIP_ROWS:  strip_rows  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes in use are clipped to the storage dimension.
  assign n_use    = (32'(matrix_size) > MAX_N) ? dmm_pkg::CFG_W'(MAX_N) : matrix_size;
  assign rows_use = (32'(strip_rows) > MAX_N) ? dmm_pkg::CFG_W'(MAX_N) : strip_rows;

  assign status.a_ok      = ({1'b0, row} < rows_use) && ({1'b0, col} < n_use);
  assign status.b_ok      = ({1'b0, row} < n_use) && ({1'b0, col} < n_use);
  assign status.req_ok    = status.a_ok;
  assign status.k_last    = (k == n_use - 1'b1);
  assign status.pipe_busy = s1_v | s2_v;
  assign status.out_free  = !result_valid || taken;

  assign taken   = result_valid && !result_stall;
  assign waddr   = ADDR_W'(32'(row) * MAX_N + 32'(col));
  assign a_raddr = ADDR_W'(32'(row_q) * MAX_N + 32'(k));
  assign b_raddr = ADDR_W'(32'(k) * MAX_N + 32'(col_q));

  always_ff @(posedge clk) begin
    if (ctrl.write_a) begin
      a_mem[waddr] <= value;
    end
    if (ctrl.issue) begin
      a_rd <= a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.write_b) begin
      b_mem[waddr] <= value;
    end
    if (ctrl.issue) begin
      b_rd <= b_mem[b_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      row_q <= row;
      col_q <= col;
      err_q <= !status.req_ok;
      k     <= '0;
    end else if (ctrl.issue) begin
      k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= ctrl.issue;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      mul <= a_rd * b_rd;
    end
    if (ctrl.start) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= acc + {{(dmm_pkg::PROD_W - dmm_pkg::MUL_W){mul[dmm_pkg::MUL_W-1]}}, mul};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      result_valid <= 1'b1;
    end else if (taken) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      product <= err_q ? '0 : acc;
      error   <= err_q;
    end
  end

endmodule

// ----- rtl/core/dmm_checker.sv -----
// Port-level checker for the dense matrix multiply block, bound to the top.
// Depends on dmm_pkg for widths and command codes.
module dmm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_valid,
  input logic                              item_stall,
  input logic [1:0]                        cmd,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic signed [dmm_pkg::PROD_W-1:0] product,
  input logic                              error
);

  logic item_taken;

  assign item_taken = item_valid && !item_stall;

  // A result held back keeps its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(product) && $stable(error))
    else $error("result changed while stalled");

  // A flagged result carries a zero product.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && error |-> product == '0)
    else $error("error result with nonzero product");

  // A product request occupies the block in the following cycle.
  a_request_busy: assert property (@(posedge clk) disable iff (rst)
    item_taken && cmd == dmm_pkg::CMD_REQUEST |=> item_stall)
    else $error("request did not stall the item channel");

  // A write leaves the item channel open.
  a_write_open: assert property (@(posedge clk) disable iff (rst)
    item_taken && (cmd == dmm_pkg::CMD_WRITE_A || cmd == dmm_pkg::CMD_WRITE_B)
    |=> !item_stall)
    else $error("write stalled the item channel");

endmodule

bind dense_matrix_multiply dmm_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .cmd          (cmd),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .product      (product),
  .error        (error)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for dense_matrix_multiply: directed table, then random requests.
// It keeps its own copy of the A and B stores to predict every product element.
// Depends on dmm_pkg and the dense_matrix_multiply RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_N = 64;
  localparam int DEPTH = MAX_N * MAX_N;
  // The fourth command code is unused; the block must drop it silently.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // This covers one request in flight at the largest size.
  localparam int SETTLE = MAX_N + 8;
  localparam int IDLE_PCT = 11;
  localparam int LONG_HOLD = 400;
  localparam int ITEM_TARGET = 1420;

  typedef enum logic [1:0] {PLAN_CFG, PLAN_ITEM, PLAN_TYPED} plan_kind_t;

  // One row of the directed table. Configuration rows use reg_sel/reg_val,
  // item rows use the request fields, and typed rows also carry the result.
  typedef struct {
    plan_kind_t                    kind;
    logic [1:0]                    cmd;
    logic [dmm_pkg::POS_W-1:0]     row;
    logic [dmm_pkg::POS_W-1:0]     col;
    logic signed [15:0]            value;
    logic signed [39:0]            prod;
    logic                          err;
    logic                          reg_sel;
    logic [dmm_pkg::CFG_W-1:0]     reg_val;
  } plan_step_t;

  typedef struct packed {
    logic signed [dmm_pkg::PROD_W-1:0] prod;
    logic                              err;
  } dot_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [dmm_pkg::CFG_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] cmd = dmm_pkg::CMD_WRITE_A;
  logic [dmm_pkg::POS_W-1:0] row = '0;
  logic [dmm_pkg::POS_W-1:0] col = '0;
  logic signed [dmm_pkg::VAL_W-1:0] value = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [dmm_pkg::PROD_W-1:0] product;
  logic error;

  // Mirror of the block: both element stores, which entries hold data, and
  // the two size registers as last written.
  logic signed [dmm_pkg::VAL_W-1:0] a_mem [DEPTH];
  logic signed [dmm_pkg::VAL_W-1:0] b_mem [DEPTH];
  bit a_set [DEPTH];
  bit b_set [DEPTH];
  int size_reg = dmm_pkg::CFG_RESET;
  int rows_reg = dmm_pkg::CFG_RESET;

  dot_result_t due_products [$];
  plan_step_t plan [$];
  int failures = 0;
  int counted = 0;

  // Traffic shaping shared by the sender and the receiver.
  bit calm = 1'b0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;

  dense_matrix_multiply #(.MAX_N(MAX_N)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .cmd(cmd),
    .row(row),
    .col(col),
    .value(value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .product(product),
    .error(error)
  );

  always #2 clk = ~clk;

  // The block only uses sizes up to MAX_N; larger register values clamp.
  function automatic int in_use(input int v);
    return (v > MAX_N) ? MAX_N : v;
  endfunction

  // Element values lean toward the two extremes of Q8.8.
  function automatic logic signed [dmm_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return dmm_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // Register values: mostly small sizes, sometimes zero, sometimes at or
  // past MAX_N so the clamp and the top bit of the register get exercised.
  function automatic logic [dmm_pkg::CFG_W-1:0] pick_extent();
    case ($urandom_range(19))
      0: return '0;
      1, 2: return dmm_pkg::CFG_W'($urandom_range(64, 127));
      default: return dmm_pkg::CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Applies one accepted request to the mirror. Writes land only inside the
  // configured extents; a product request always yields one result, with
  // the error flag and a zero product when row or column is out of range.
  function automatic void mirror_item(input logic [1:0] c,
                                      input logic [dmm_pkg::POS_W-1:0] r,
                                      input logic [dmm_pkg::POS_W-1:0] k_col,
                                      input logic signed [dmm_pkg::VAL_W-1:0] v,
                                      output bit makes_result, output bit used,
                                      output dot_result_t res);
    int n;
    int rows;
    longint acc;
    n = in_use(size_reg);
    rows = in_use(rows_reg);
    makes_result = 1'b0;
    used = 1'b0;
    res = '0;
    acc = 0;
    case (c)
      dmm_pkg::CMD_WRITE_A: begin
        if (r < rows && k_col < n) begin
          a_mem[r * MAX_N + k_col] = v;
          a_set[r * MAX_N + k_col] = 1'b1;
          used = 1'b1;
        end
      end
      dmm_pkg::CMD_WRITE_B: begin
        if (r < n && k_col < n) begin
          b_mem[r * MAX_N + k_col] = v;
          b_set[r * MAX_N + k_col] = 1'b1;
          used = 1'b1;
        end
      end
      dmm_pkg::CMD_REQUEST: begin
        makes_result = 1'b1;
        used = 1'b1;
        if (r >= rows || k_col >= n) begin
          res.err = 1'b1;
        end else begin
          for (int k = 0; k < n; k++) begin
            acc += longint'(a_mem[r * MAX_N + k]) * longint'(b_mem[k * MAX_N + k_col]);
          end
          res.prod = acc[dmm_pkg::PROD_W-1:0];
        end
      end
      default: ;
    endcase
  endfunction

  // Offers one request on the item channel and returns at the edge that
  // accepts it, with valid still high. Valid only drops during an idle gap,
  // so it is never lowered and raised within one time step.
  task automatic send_item(input logic [1:0] c, input logic [dmm_pkg::POS_W-1:0] r,
                           input logic [dmm_pkg::POS_W-1:0] k_col,
                           input logic signed [dmm_pkg::VAL_W-1:0] v,
                           input bit typed, input logic signed [dmm_pkg::PROD_W-1:0] t_prod,
                           input logic t_err);
    bit makes_result;
    bit used;
    dot_result_t res;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd <= c;
    row <= r;
    col <= k_col;
    value <= v;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    mirror_item(c, r, k_col, v, makes_result, used, res);
    if (used) counted++;
    if (makes_result) begin
      if (typed) begin
        res.prod = t_prod;
        res.err = t_err;
      end
      due_products.push_back(res);
    end
  endtask

  // Register writes happen only with the block idle: the item channel is
  // released, every outstanding product has come back, and a request's
  // worth of cycles has passed in case trailing writes are still landing.
  task automatic write_register(input logic sel, input logic [dmm_pkg::CFG_W-1:0] val);
    item_valid <= 1'b0;
    @(posedge clk);
    while (due_products.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (sel == dmm_pkg::REG_MATRIX_SIZE) size_reg = val;
    else rows_reg = val;
  endtask

  // Issues a product request. When it is in range, every A element of the
  // row and B element of the column that was never written gets a random
  // value first, so the block never reads an undefined element.
  task automatic request_dot(input logic [dmm_pkg::POS_W-1:0] r,
                             input logic [dmm_pkg::POS_W-1:0] k_col);
    int n;
    int rows;
    n = in_use(size_reg);
    rows = in_use(rows_reg);
    if (r < rows && k_col < n) begin
      for (int k = 0; k < n; k++) begin
        if (!a_set[r * MAX_N + k])
          send_item(dmm_pkg::CMD_WRITE_A, r, dmm_pkg::POS_W'(k), pick_value(), 0, 0, 0);
      end
      for (int k = 0; k < n; k++) begin
        if (!b_set[k * MAX_N + k_col])
          send_item(dmm_pkg::CMD_WRITE_B, dmm_pkg::POS_W'(k), k_col, pick_value(), 0, 0, 0);
      end
    end
    send_item(dmm_pkg::CMD_REQUEST, r, k_col, 0, 0, 0, 0);
  endtask

  // Result side: random stall, no stall during the calm stretch, and one
  // long hold-off on request so the block fills and stalls its input.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left <= LONG_HOLD;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Every accepted result is checked against the oldest expected product.
  always @(posedge clk) begin : check_results
    dot_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (due_products.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: product %0d error %0d", product, error);
      end else begin
        want = due_products.pop_front();
        if (product !== want.prod || error !== want.err) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected product %0d error %0d, got product %0d error %0d",
                     want.prod, want.err, product, error);
        end
      end
    end
  end

  initial begin : stimulus
    int n;
    int rows;
    int pick;
    int phase_len;
    int phase_start;
    bit hold_done;
    logic [1:0] c;
    logic [dmm_pkg::POS_W-1:0] r;
    logic [dmm_pkg::POS_W-1:0] k_col;

    hold_done = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Size one, one row: the extreme products of a single term.
    plan.push_back('{PLAN_CFG, dmm_pkg::CMD_WRITE_A, 0, 0, 0, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 1});
    plan.push_back('{PLAN_CFG, dmm_pkg::CMD_WRITE_A, 0, 0, 0, 0, 0,
                     dmm_pkg::REG_STRIP_ROWS, 1});
    plan.push_back('{PLAN_ITEM, dmm_pkg::CMD_WRITE_A, 0, 0, 16'sh8000, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_ITEM, dmm_pkg::CMD_WRITE_B, 0, 0, 16'sh8000, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_TYPED, dmm_pkg::CMD_REQUEST, 0, 0, 0, 40'sd1073741824, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    // Requests past the row count or the size come back flagged.
    plan.push_back('{PLAN_TYPED, dmm_pkg::CMD_REQUEST, 1, 0, 0, 0, 1,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_TYPED, dmm_pkg::CMD_REQUEST, 0, 1, 0, 0, 1,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_TYPED, dmm_pkg::CMD_REQUEST, 63, 63, 0, 0, 1,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_ITEM, dmm_pkg::CMD_WRITE_A, 0, 0, 16'sh7FFF, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_TYPED, dmm_pkg::CMD_REQUEST, 0, 0, 0, -40'sd1073709056, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_ITEM, dmm_pkg::CMD_WRITE_B, 0, 0, 16'sh7FFF, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_TYPED, dmm_pkg::CMD_REQUEST, 0, 0, 0, 40'sd1073676289, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    // Out-of-range writes and the unused command must leave the stores alone.
    plan.push_back('{PLAN_ITEM, dmm_pkg::CMD_WRITE_A, 1, 0, 16'sh1234, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_ITEM, dmm_pkg::CMD_WRITE_B, 0, 1, 16'sh1234, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_ITEM, CMD_UNUSED, 0, 0, 16'shFFFF, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_TYPED, dmm_pkg::CMD_REQUEST, 0, 0, 0, 40'sd1073676289, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    // A size of zero and a row count of zero reject every request.
    plan.push_back('{PLAN_CFG, dmm_pkg::CMD_WRITE_A, 0, 0, 0, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_TYPED, dmm_pkg::CMD_REQUEST, 0, 0, 0, 0, 1,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_CFG, dmm_pkg::CMD_WRITE_A, 0, 0, 0, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 127});
    plan.push_back('{PLAN_CFG, dmm_pkg::CMD_WRITE_A, 0, 0, 0, 0, 0,
                     dmm_pkg::REG_STRIP_ROWS, 0});
    plan.push_back('{PLAN_TYPED, dmm_pkg::CMD_REQUEST, 0, 0, 0, 0, 1,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    // Two by two: a real two-term dot product, then one element changed.
    plan.push_back('{PLAN_CFG, dmm_pkg::CMD_WRITE_A, 0, 0, 0, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 2});
    plan.push_back('{PLAN_CFG, dmm_pkg::CMD_WRITE_A, 0, 0, 0, 0, 0,
                     dmm_pkg::REG_STRIP_ROWS, 2});
    plan.push_back('{PLAN_ITEM, dmm_pkg::CMD_WRITE_A, 1, 0, 16'sh0100, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_ITEM, dmm_pkg::CMD_WRITE_A, 1, 1, 16'sh8000, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_ITEM, dmm_pkg::CMD_WRITE_B, 0, 1, 16'sh7FFF, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_ITEM, dmm_pkg::CMD_WRITE_B, 1, 1, 16'shFF00, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_ITEM, dmm_pkg::CMD_REQUEST, 1, 1, 0, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_ITEM, dmm_pkg::CMD_WRITE_A, 1, 1, 16'sh0000, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_ITEM, dmm_pkg::CMD_REQUEST, 1, 1, 0, 0, 0,
                     dmm_pkg::REG_MATRIX_SIZE, 0});
    plan.push_back('{PLAN_TYPED, dmm_pkg::CMD_REQUEST, 63, 0, 0, 0, 1,
                     dmm_pkg::REG_MATRIX_SIZE, 0});

    foreach (plan[i]) begin
      case (plan[i].kind)
        PLAN_CFG: write_register(plan[i].reg_sel, plan[i].reg_val);
        PLAN_TYPED: send_item(plan[i].cmd, plan[i].row, plan[i].col, plan[i].value,
                              1, plan[i].prod, plan[i].err);
        default: send_item(plan[i].cmd, plan[i].row, plan[i].col, plan[i].value, 0, 0, 0);
      endcase
    end

    // Random part, in phases with a fresh pair of sizes each. Most items are
    // in-range requests and writes; the rest probe the range checks and the
    // unused command. Large sizes get longer phases since fills dominate.
    while (counted < ITEM_TARGET) begin
      write_register(dmm_pkg::REG_MATRIX_SIZE, pick_extent());
      write_register(dmm_pkg::REG_STRIP_ROWS, pick_extent());
      n = in_use(size_reg);
      rows = in_use(rows_reg);
      phase_len = (n > 16) ? 150 : 100;
      phase_start = counted;
      while (counted - phase_start < phase_len && counted < ITEM_TARGET) begin
        // A stretch with no idling on either side, then the long hold-off.
        calm <= (counted >= 300 && counted < 550);
        if (!hold_done && counted >= 700) begin
          holds_asked <= holds_asked + 1;
          hold_done = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 45) begin
          r = (rows > 0) ? dmm_pkg::POS_W'($urandom_range(rows - 1))
                         : dmm_pkg::POS_W'($urandom);
          k_col = (n > 0) ? dmm_pkg::POS_W'($urandom_range(n - 1))
                          : dmm_pkg::POS_W'($urandom);
          request_dot(r, k_col);
        end else if (pick < 75) begin
          c = $urandom_range(1) ? dmm_pkg::CMD_WRITE_B : dmm_pkg::CMD_WRITE_A;
          if (c == dmm_pkg::CMD_WRITE_A)
            r = (rows > 0) ? dmm_pkg::POS_W'($urandom_range(rows - 1))
                           : dmm_pkg::POS_W'($urandom);
          else
            r = (n > 0) ? dmm_pkg::POS_W'($urandom_range(n - 1))
                        : dmm_pkg::POS_W'($urandom);
          k_col = (n > 0) ? dmm_pkg::POS_W'($urandom_range(n - 1))
                          : dmm_pkg::POS_W'($urandom);
          send_item(c, r, k_col, pick_value(), 0, 0, 0);
        end else if (pick < 87) begin
          request_dot(dmm_pkg::POS_W'($urandom), dmm_pkg::POS_W'($urandom));
        end else if (pick < 96) begin
          c = $urandom_range(1) ? dmm_pkg::CMD_WRITE_B : dmm_pkg::CMD_WRITE_A;
          send_item(c, dmm_pkg::POS_W'($urandom), dmm_pkg::POS_W'($urandom),
                    pick_value(), 0, 0, 0);
        end else begin
          send_item(CMD_UNUSED, dmm_pkg::POS_W'($urandom), dmm_pkg::POS_W'($urandom),
                    pick_value(), 0, 0, 0);
        end
      end
    end

    // Drain: every expected product back, then a quiet tail for strays.
    item_valid <= 1'b0;
    calm <= 1'b0;
    @(posedge clk);
    while (due_products.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (failures == 0 && due_products.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("testbench failed");
    $finish;
  end

endmodule
